// ----- design/htbd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package htbd_pkg;
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_BUILD  = 2'd1;
    localparam logic [1:0] OP_DECODE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NO_TREE = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    localparam int SYMBOL_SPACE = 256;
endpackage
`default_nettype wire

// ----- design/huffman_tree_build_and_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  tdata fields (low bit first)                     tuser
// s_axis   in   symbol[7:0], weight[23:8], code_bit[24]            opcode[1:0]
// m_axis   out  decoded_symbol[7:0], status[9:8], leaf_total[18:10] symbol_valid
// Each transaction runs through one shared compare/shift sequencer on the node
// memories. Load scans the leaves and shifts them to insert a new symbol.
// Build merges nodes through a serial lightest-node search (two passes per
// merge). Decode reads the walk node, then its child from the child memory.
// Clear, empty build and decode without tree go straight to the result.
// Reset clears control state only; s_axis_tready is low while an item is in
// work or its result waits on m_axis.
module huffman_tree_build_and_decode #(
    parameter int MAX_SYMBOLS = 256,
    parameter int WEIGHT_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // symbol, weight, code_bit
    input  wire  [1:0]  s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,   // decoded_symbol, status, leaf_total
    output logic        m_axis_tuser    // symbol_valid
);
    localparam int DEPTH = 2 * MAX_SYMBOLS - 1;
    localparam int AW = $clog2(DEPTH + 1);
    localparam int CW = $clog2(MAX_SYMBOLS + 1);
    localparam int NW = WEIGHT_BITS + AW;
    localparam int LIMIT = (MAX_SYMBOLS < htbd_pkg::SYMBOL_SPACE) ?
                           MAX_SYMBOLS : htbd_pkg::SYMBOL_SPACE;
    localparam logic [CW-1:0] LIMIT_C = CW'(LIMIT);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LSCAN = 4'd1;
    localparam logic [3:0] S_LSHFT = 4'd2;
    localparam logic [3:0] S_BINIT = 4'd3;
    localparam logic [3:0] S_SRCH  = 4'd4;
    localparam logic [3:0] S_MERGE = 4'd5;
    localparam logic [3:0] S_DRD   = 4'd6;
    localparam logic [3:0] S_DCHK  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_DWAIT = 4'd9;
    localparam logic [3:0] S_LWAIT = 4'd10;
    localparam logic [3:0] S_SWAIT = 4'd11;

    // node memories
    logic [NW-1:0]   m_wt   [DEPTH];
    logic [AW-1:0]   m_lc   [DEPTH];
    logic [AW-1:0]   m_rc   [DEPTH];
    logic            m_leaf [DEPTH];
    logic [7:0]      m_sym  [DEPTH];
    logic            m_act  [DEPTH];

    logic [3:0]      r_state;
    logic [CW-1:0]   r_cnt;
    logic [AW-1:0]   r_root, r_walk, r_n, r_i, r_pos, r_best, r_a;
    logic            r_ready, r_found, r_second;
    logic [NW-1:0]   r_bestw, r_aw;
    logic [7:0]      r_isym;
    logic [WEIGHT_BITS-1:0] r_iw;
    logic            r_bit;
    logic [7:0]      r_osym;
    logic            r_oval;
    logic [1:0]      r_ostat;

    // registered read port
    logic [AW-1:0]   rd_addr;
    logic [NW-1:0]   r_rd_wt;
    logic [AW-1:0]   r_rd_lc, r_rd_rc;
    logic            r_rd_leaf, r_rd_act;
    logic [7:0]      r_rd_sym;

    always_ff @(posedge i_clk) begin
        r_rd_wt   <= m_wt[rd_addr];
        r_rd_lc   <= m_lc[rd_addr];
        r_rd_rc   <= m_rc[rd_addr];
        r_rd_leaf <= m_leaf[rd_addr];
        r_rd_act  <= m_act[rd_addr];
        r_rd_sym  <= m_sym[rd_addr];
    end

    logic [AW-1:0] cnt_ext;
    assign cnt_ext = AW'(r_cnt);

    always_comb begin
        rd_addr = r_i;
        if (r_state == S_IDLE) rd_addr = r_walk;
    end

    assign s_axis_tready = (r_state == S_IDLE) && !m_axis_tvalid;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {5'd0, 9'(r_cnt), r_ostat, r_osym};
    assign m_axis_tuser  = r_oval;

    logic [AW-1:0] child;
    assign child = r_bit ? r_rd_rc : r_rd_lc;

    // candidate picks for the node under compare
    logic          take_a, take_b;
    logic [AW-1:0] pick_b;
    logic [NW-1:0] pick_bw;
    assign take_a  = r_rd_act && (!r_found || r_rd_wt < r_bestw);
    assign take_b  = take_a && (r_i != r_a);
    assign pick_b  = take_b ? r_i : r_best;
    assign pick_bw = take_b ? r_rd_wt : r_bestw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_root  <= '0;
            r_walk  <= '0;
            r_ready <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_isym <= s_axis_tdata[7:0];
                    r_iw   <= WEIGHT_BITS'(s_axis_tdata[23:8]);
                    r_bit  <= s_axis_tdata[24];
                    r_osym <= '0;
                    r_oval <= 1'b0;
                    r_ostat <= htbd_pkg::ST_OK;
                    r_i    <= '0;
                    unique case (s_axis_tuser)
                        htbd_pkg::OP_LOAD: begin
                            r_ready <= 1'b0;
                            r_state <= S_LWAIT;
                        end
                        htbd_pkg::OP_BUILD: begin
                            r_ready <= 1'b0;
                            if (r_cnt == '0) begin
                                r_ostat <= htbd_pkg::ST_EMPTY;
                                r_state <= S_OUT;
                            end else r_state <= S_BINIT;
                        end
                        htbd_pkg::OP_DECODE: begin
                            if (!r_ready) begin
                                r_ostat <= htbd_pkg::ST_NO_TREE;
                                r_state <= S_OUT;
                            end else begin
                                // rd_addr = walk; a single leaf root is walk==root
                                r_state <= S_DRD;
                            end
                        end
                        default: begin
                            r_cnt   <= '0;
                            r_root  <= '0;
                            r_walk  <= '0;
                            r_ready <= 1'b0;
                            r_state <= S_OUT;
                        end
                    endcase
                end
                S_LWAIT: begin
                    // read of leaf r_i in flight
                    if (r_i >= cnt_ext) begin
                        r_pos <= r_i;
                        if (r_cnt >= LIMIT_C) begin
                            r_ostat <= htbd_pkg::ST_FULL;
                            r_state <= S_OUT;
                        end else begin
                            r_i <= cnt_ext;
                            r_state <= S_LSHFT;
                        end
                    end else r_state <= S_LSCAN;
                end
                S_LSCAN: begin
                    if (r_rd_sym < r_isym) begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_LWAIT;
                    end else if (r_rd_sym == r_isym) begin
                        m_wt[r_i] <= NW'(r_iw);
                        r_state <= S_OUT;
                    end else begin
                        r_pos <= r_i;
                        if (r_cnt >= LIMIT_C) begin
                            r_ostat <= htbd_pkg::ST_FULL;
                            r_state <= S_OUT;
                        end else begin
                            r_i <= cnt_ext - 1'b1;
                            r_state <= S_SWAIT;
                        end
                    end
                end
                S_SWAIT: r_state <= S_LSHFT;
                S_LSHFT: begin
                    // r_i names the source (r_i) for dest r_i+1, or the insert slot
                    if (r_i == r_pos && r_state == S_LSHFT && r_i == cnt_ext) begin
                        m_wt[r_pos]  <= NW'(r_iw);
                        m_sym[r_pos] <= r_isym;
                        r_cnt <= r_cnt + 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        m_wt[r_i + 1'b1]  <= r_rd_wt;
                        m_sym[r_i + 1'b1] <= r_rd_sym;
                        if (r_i == r_pos) begin
                            m_wt[r_pos]  <= NW'(r_iw);
                            m_sym[r_pos] <= r_isym;
                            r_cnt <= r_cnt + 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_i <= r_i - 1'b1;
                            r_state <= S_SWAIT;
                        end
                    end
                end
                S_BINIT: begin
                    m_leaf[r_i] <= 1'b1;
                    m_act[r_i]  <= 1'b1;
                    m_lc[r_i]   <= '0;
                    m_rc[r_i]   <= '0;
                    if (r_i == cnt_ext - 1'b1) begin
                        r_n <= cnt_ext;
                        r_i <= '0;
                        r_found <= 1'b0;
                        r_second <= 1'b0;
                        if (r_cnt == CW'(1)) begin
                            r_root <= '0;
                            r_walk <= '0;
                            r_ready <= 1'b1;
                            r_state <= S_OUT;
                        end else r_state <= S_MERGE;
                    end else r_i <= r_i + 1'b1;
                end
                S_MERGE: begin
                    // issue read of r_i, compare next cycle
                    r_state <= S_SRCH;
                end
                S_SRCH: begin
                    if (r_i == r_n - 1'b1) begin
                        r_i <= '0;
                        r_found <= 1'b0;
                        if (!r_second) begin
                            r_second <= 1'b1;
                            r_a  <= take_a ? r_i : r_best;
                            r_aw <= take_a ? r_rd_wt : r_bestw;
                            m_lc[r_n] <= take_a ? r_i : r_best;
                            // the second pass stops below r_n, so mark the parent now
                            m_act[r_n] <= 1'b1;
                            r_state <= S_MERGE;
                        end else begin
                            m_rc[r_n]   <= pick_b;
                            m_act[pick_b] <= 1'b0;
                            m_act[r_a]  <= 1'b0;
                            m_wt[r_n]   <= r_aw + pick_bw;
                            m_leaf[r_n] <= 1'b0;
                            m_sym[r_n]  <= '0;
                            r_second <= 1'b0;
                            if (r_n == AW'(2) * cnt_ext - AW'(2)) begin
                                r_root <= r_n;
                                r_walk <= r_n;
                                r_ready <= 1'b1;
                                r_state <= S_OUT;
                            end else begin
                                r_n <= r_n + 1'b1;
                                r_state <= S_MERGE;
                            end
                        end
                    end else begin
                        if (take_a && !(r_second && r_i == r_a)) begin
                            r_best <= r_i;
                            r_bestw <= r_rd_wt;
                            r_found <= 1'b1;
                        end
                        r_i <= r_i + 1'b1;
                        r_state <= S_MERGE;
                    end
                end
                S_DRD: begin
                    // r_rd_* holds walk node; single-leaf root handled here
                    if (r_rd_leaf) begin
                        r_oval <= 1'b1;
                        r_osym <= r_rd_sym;
                        r_walk <= r_root;
                        r_state <= S_OUT;
                    end else begin
                        r_i <= child;
                        r_state <= S_DWAIT;
                    end
                end
                S_DWAIT: r_state <= S_DCHK;
                S_DCHK: begin
                    if (r_rd_leaf) begin
                        r_oval <= 1'b1;
                        r_osym <= r_rd_sym;
                        r_walk <= r_root;
                    end else r_walk <= r_i;
                    r_state <= S_OUT;
                end
                S_OUT: if (m_axis_tready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
